>>> sv/mecanum_wheel_mixer_unit_macros.svh
// Assertion macros shared by the mixer RTL.
`ifndef MECANUM_WHEEL_MIXER_UNIT_MACROS_SVH
`define MECANUM_WHEEL_MIXER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MWM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MWM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MWM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MWM_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> sv/mwm_pkg.sv
`default_nettype none

package mwm_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;

   // command axes
   localparam int NUM_AXES   = 3;
   localparam int AX_STRAFE  = 0;
   localparam int AX_FORWARD = 1;
   localparam int AX_ROTATE  = 2;

   // roller layout codes
   localparam logic LAYOUT_CENTER = 1'b0;
   localparam logic LAYOUT_AXES   = 1'b1;

endpackage

`default_nettype wire

>>> sv/mwm_if.sv
`default_nettype none

// command channel
interface mwm_req_if
   import mwm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] strafe_cmd;
   logic signed [SAMPLE_BITS-1:0] forward_cmd;
   logic signed [SAMPLE_BITS-1:0] rotate_cmd;

   modport source (output valid, output strafe_cmd, output forward_cmd,
                   output rotate_cmd, input ready);
   modport sink   (input valid, input strafe_cmd, input forward_cmd,
                   input rotate_cmd, output ready);
endinterface

// wheel speed channel
interface mwm_rsp_if
   import mwm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] front_left_speed;
   logic signed [SAMPLE_BITS-1:0] front_right_speed;
   logic signed [SAMPLE_BITS-1:0] rear_left_speed;
   logic signed [SAMPLE_BITS-1:0] rear_right_speed;

   modport source (output valid, output front_left_speed, output front_right_speed,
                   output rear_left_speed, output rear_right_speed, input ready);
   modport sink   (input valid, input front_left_speed, input front_right_speed,
                   input rear_left_speed, input rear_right_speed, output ready);
endinterface

`default_nettype wire

>>> sv/mwm_div.sv
`default_nettype none
`include "mecanum_wheel_mixer_unit_macros.svh"

// Pipelined restoring divider: three numerators over one shared divisor,
// one quotient bit per stage, most significant bit first.
module mwm_div
   import mwm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output      logic                      in_ready,
   input  wire logic [2*SAMPLE_BITS-2:0]  in_num [NUM_AXES],
   input  wire logic [SAMPLE_BITS:0]      in_den,
   input  wire logic [NUM_AXES-1:0]       in_sign,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      logic [SAMPLE_BITS-1:0]    out_quo [NUM_AXES],
   output      logic [NUM_AXES-1:0]       out_sign
);

   localparam int FB = SAMPLE_BITS - 1;
   localparam int MW = FB + 1;
   localparam int SW = FB + 2;
   localparam int NW = 2 * FB + 1;
   localparam int DW = 2 * FB + 2;
   localparam int NS = FB + 1;
   localparam logic [MW-1:0] ONE_Q = {1'b1, {FB{1'b0}}};

   logic                vld_ff [NS];
   logic [NW-1:0]       rem_ff [NS][NUM_AXES];
   logic [MW-1:0]       quo_ff [NS][NUM_AXES];
   logic [SW-1:0]       den_ff [NS];
   logic [NUM_AXES-1:0] sgn_ff [NS];

   logic                src_vld [NS];
   logic [NW-1:0]       src_rem [NS][NUM_AXES];
   logic [MW-1:0]       src_quo [NS][NUM_AXES];
   logic [SW-1:0]       src_den [NS];
   logic [NUM_AXES-1:0] src_sgn [NS];
   logic [NS:0]         en;

   assign en[NS]    = out_ready;
   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];
   assign out_quo   = quo_ff[NS-1];
   assign out_sign  = sgn_ff[NS-1];

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam int K = FB - j;
      logic [DW-1:0] dsh;

      if (j == 0) begin : g_first
         assign src_vld[j] = in_valid;
         assign src_den[j] = in_den;
         assign src_sgn[j] = in_sign;
         for (genvar i = 0; i < NUM_AXES; i++) begin : g_ax
            assign src_rem[j][i] = in_num[i];
            assign src_quo[j][i] = '0;
         end
      end else begin : g_next
         assign src_vld[j] = vld_ff[j-1];
         assign src_den[j] = den_ff[j-1];
         assign src_sgn[j] = sgn_ff[j-1];
         for (genvar i = 0; i < NUM_AXES; i++) begin : g_ax
            assign src_rem[j][i] = rem_ff[j-1][i];
            assign src_quo[j][i] = quo_ff[j-1][i];
         end
      end

      // advance when empty or when the stage ahead moves
      assign en[j] = !vld_ff[j] || en[j+1];
      assign dsh   = DW'(src_den[j]) << K;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en[j]) begin
            vld_ff[j] <= src_vld[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            den_ff[j] <= src_den[j];
            sgn_ff[j] <= src_sgn[j];
         end
      end

      for (genvar i = 0; i < NUM_AXES; i++) begin : g_ax
         logic [DW:0]   diff;
         logic          ge;
         logic [NW-1:0] rem_in;
         logic [MW-1:0] quo_in;

         assign diff   = {1'b0, DW'(src_rem[j][i])} - {1'b0, dsh};
         assign ge     = !diff[DW];
         assign rem_in = ge ? diff[NW-1:0] : src_rem[j][i];
         assign quo_in = src_quo[j][i] | (MW'(ge) << K);

         always_ff @(posedge clock) begin
            if (en[j]) begin
               rem_ff[j][i] <= rem_in;
               quo_ff[j][i] <= quo_in;
            end
         end
      end
   end

   `MWM_ASSERT_IMP(a_quo_range, clock, reset, out_valid, (out_quo[0] <= ONE_Q) && (out_quo[1] <= ONE_Q) && (out_quo[2] <= ONE_Q), "quotient above one")
   `MWM_ASSERT_IMP(a_rem_range, clock, reset, out_valid, (rem_ff[NS-1][0] < NW'(den_ff[NS-1])) && (rem_ff[NS-1][1] < NW'(den_ff[NS-1])) && (rem_ff[NS-1][2] < NW'(den_ff[NS-1])), "remainder not below divisor")
   `MWM_ASSERT_NXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(out_sign) && $stable(out_quo[0]) && $stable(out_quo[1]) && $stable(out_quo[2]), "stalled quotient word changed")

endmodule

`default_nettype wire

>>> sv/mecanum_wheel_mixer_unit.sv
`default_nettype none
`include "mecanum_wheel_mixer_unit_macros.svh"

// Channel   | Dir | Payload                                       | Handshake
// ----------+-----+-----------------------------------------------+-------------
// req_port  | in  | strafe_cmd, forward_cmd, rotate_cmd (Q1.F)    | valid/ready
// rsp_port  | out | front/rear left/right wheel speeds (Q1.F)     | valid/ready
// csr_*     | in  | roller_layout, one bit                        | write enable
//
// Takes one word per cycle unless a stalled rsp_port backs up the pipeline; a word passes
// five shaping and normalization stages, one divider stage per quotient bit, output register.
// Synchronous active-high reset empties every stage and selects rollers-toward-center.
// Each stage loads when it is empty or the stage ahead advances, so a stalled
// rsp_port fills bubbles first and only then drops req_port.ready.
module mecanum_wheel_mixer_unit
   import mwm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mwm_req_if.sink    req_port,
   mwm_rsp_if.source  rsp_port,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data
);

   localparam int FB = SAMPLE_BITS - 1;   // fraction bits
   localparam int MW = FB + 1;            // magnitude, 0..ONE
   localparam int PW = 2 * MW;            // product
   localparam int SW = FB + 2;            // sum of magnitudes, up to 3*ONE
   localparam int NW = 2 * FB + 1;        // divider numerator
   localparam int WW = FB + 3;            // signed wheel sum

   localparam logic [MW-1:0] ONE_Q   = {1'b1, {FB{1'b0}}};
   localparam logic [SW-1:0] ONE_S   = SW'(ONE_Q);
   localparam logic [SW-1:0] DEN_MAX = SW'(3) << FB;
   localparam logic [PW-1:0] RND     = PW'(1) << (FB - 1);
   localparam logic signed [WW-1:0] SAT_HI = WW'({1'b0, {FB{1'b1}}});
   localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

   // saturate a wheel sum to [-ONE, ONE-1]
   function automatic logic [MW-1:0] sat(input logic signed [WW-1:0] v);
      logic [MW-1:0] res;
      if (v > SAT_HI) begin
         res = SAT_HI[MW-1:0];
      end else if (v < SAT_LO) begin
         res = SAT_LO[MW-1:0];
      end else begin
         res = v[MW-1:0];
      end
      return res;
   endfunction

   // ---------------- configuration ----------------
   logic roller_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         roller_ff <= LAYOUT_CENTER;
      end else if (csr_write_enable) begin
         roller_ff <= csr_write_data;
      end
   end

   // ---------------- stage enables ----------------
   logic en1, en2, en3, en4, en5, en_out;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, out_vld_ff;
   logic div_in_ready, div_out_valid;

   assign en_out = !out_vld_ff || rsp_port.ready;
   assign en5    = !s5_vld_ff || div_in_ready;
   assign en4    = !s4_vld_ff || en5;
   assign en3    = !s3_vld_ff || en4;
   assign en2    = !s2_vld_ff || en3;
   assign en1    = !s1_vld_ff || en2;
   assign req_port.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (en1)    s1_vld_ff  <= req_port.valid;
         if (en2)    s2_vld_ff  <= s1_vld_ff;
         if (en3)    s3_vld_ff  <= s2_vld_ff;
         if (en4)    s4_vld_ff  <= s3_vld_ff;
         if (en5)    s5_vld_ff  <= s4_vld_ff;
         if (en_out) out_vld_ff <= div_out_valid;
      end
   end

   // ---------------- stage 1: magnitude and sign ----------------
   logic [MW-1:0]       cmd [NUM_AXES];
   logic [MW-1:0]       a_in [NUM_AXES];
   logic [NUM_AXES-1:0] sgn_in;
   logic [MW-1:0]       a1_ff [NUM_AXES];
   logic [NUM_AXES-1:0] sgn1_ff;

   assign cmd[AX_STRAFE]  = req_port.strafe_cmd;
   assign cmd[AX_FORWARD] = req_port.forward_cmd;
   assign cmd[AX_ROTATE]  = req_port.rotate_cmd;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_abs
      logic [MW:0] neg;
      // most negative command gives exactly ONE
      assign neg       = -{cmd[i][MW-1], cmd[i]};
      assign sgn_in[i] = cmd[i][MW-1];
      assign a_in[i]   = cmd[i][MW-1] ? neg[MW-1:0] : cmd[i];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         a1_ff   <= a_in;
         sgn1_ff <= sgn_in;
      end
   end

   // ---------------- stage 2: rounded squares ----------------
   logic [MW-1:0]       sq_in [NUM_AXES];
   logic [MW-1:0]       sq2_ff [NUM_AXES];
   logic [MW-1:0]       ar2_ff;
   logic [NUM_AXES-1:0] sgn2_ff;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_sq
      logic [PW-1:0] prod;
      assign prod     = PW'(a1_ff[i]) * PW'(a1_ff[i]) + RND;
      assign sq_in[i] = prod[FB +: MW];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         sq2_ff  <= sq_in;
         ar2_ff  <= a1_ff[AX_ROTATE];
         sgn2_ff <= sgn1_ff;
      end
   end

   // ---------------- stage 3: rotate cube ----------------
   logic [PW-1:0]       cube_prod;
   logic [MW-1:0]       m3_ff [NUM_AXES];
   logic [NUM_AXES-1:0] sgn3_ff;

   assign cube_prod = PW'(sq2_ff[AX_ROTATE]) * PW'(ar2_ff) + RND;

   always_ff @(posedge clock) begin
      if (en3) begin
         m3_ff[AX_STRAFE]  <= sq2_ff[AX_STRAFE];
         m3_ff[AX_FORWARD] <= sq2_ff[AX_FORWARD];
         m3_ff[AX_ROTATE]  <= cube_prod[FB +: MW];
         sgn3_ff           <= sgn2_ff;
      end
   end

   // ---------------- stage 4: sum of magnitudes ----------------
   logic [SW-1:0]       sum_in;
   logic [SW-1:0]       s4_ff;
   logic [MW-1:0]       m4_ff [NUM_AXES];
   logic [NUM_AXES-1:0] sgn4_ff;

   assign sum_in = SW'(m3_ff[AX_STRAFE]) + SW'(m3_ff[AX_FORWARD]) + SW'(m3_ff[AX_ROTATE]);

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_ff   <= sum_in;
         m4_ff   <= m3_ff;
         sgn4_ff <= sgn3_ff;
      end
   end

   // ---------------- stage 5: divider operands ----------------
   // Below or at one, divide by ONE: the quotient is then the magnitude itself.
   logic [SW-1:0]       den_in;
   logic [NW-1:0]       num_in [NUM_AXES];
   logic [SW-1:0]       den5_ff;
   logic [NW-1:0]       num5_ff [NUM_AXES];
   logic [NUM_AXES-1:0] sgn5_ff;

   assign den_in = (s4_ff > ONE_S) ? s4_ff : ONE_S;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_num
      assign num_in[i] = (NW'(m4_ff[i]) << FB) + NW'(den_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         den5_ff <= den_in;
         num5_ff <= num_in;
         sgn5_ff <= sgn4_ff;
      end
   end

   // ---------------- divider ----------------
   logic [MW-1:0]       quo [NUM_AXES];
   logic [NUM_AXES-1:0] quo_sign;

   mwm_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_vld_ff),
      .in_ready  (div_in_ready),
      .in_num    (num5_ff),
      .in_den    (den5_ff),
      .in_sign   (sgn5_ff),
      .out_valid (div_out_valid),
      .out_ready (en_out),
      .out_quo   (quo),
      .out_sign  (quo_sign)
   );

   // ---------------- output: wheel mix and saturation ----------------
   logic signed [WW-1:0] ax_val [NUM_AXES];
   logic signed [WW-1:0] x_lay;
   logic signed [WW-1:0] fl_sum, fr_sum, rl_sum, rr_sum;
   logic [MW-1:0]        fl_in, fr_in, rl_in, rr_in;
   logic [MW-1:0]        fl_ff, fr_ff, rl_ff, rr_ff;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_sign
      assign ax_val[i] = quo_sign[i] ? -WW'(quo[i]) : WW'(quo[i]);
   end

   // swapped layout flips the strafe term on every wheel
   assign x_lay  = (roller_ff == LAYOUT_AXES) ? -ax_val[AX_STRAFE] : ax_val[AX_STRAFE];
   assign fl_sum = -x_lay + ax_val[AX_FORWARD] + ax_val[AX_ROTATE];
   assign fr_sum =  x_lay + ax_val[AX_FORWARD] - ax_val[AX_ROTATE];
   assign rl_sum =  x_lay + ax_val[AX_FORWARD] + ax_val[AX_ROTATE];
   assign rr_sum = -x_lay + ax_val[AX_FORWARD] - ax_val[AX_ROTATE];

   // left motors are wired inverted
   assign fl_in = sat(-fl_sum);
   assign fr_in = sat(fr_sum);
   assign rl_in = sat(-rl_sum);
   assign rr_in = sat(rr_sum);

   always_ff @(posedge clock) begin
      if (en_out) begin
         fl_ff <= fl_in;
         fr_ff <= fr_in;
         rl_ff <= rl_in;
         rr_ff <= rr_in;
      end
   end

   assign rsp_port.valid             = out_vld_ff;
   assign rsp_port.front_left_speed  = fl_ff;
   assign rsp_port.front_right_speed = fr_ff;
   assign rsp_port.rear_left_speed   = rl_ff;
   assign rsp_port.rear_right_speed  = rr_ff;

   `MWM_ASSERT_NXT(a_load_s1, clock, reset, req_port.valid && req_port.ready, s1_vld_ff, "accepted word not in stage one")
   `MWM_ASSERT_IMP(a_mag_range, clock, reset, s4_vld_ff, (m4_ff[0] <= ONE_Q) && (m4_ff[1] <= ONE_Q) && (m4_ff[2] <= ONE_Q), "shaped magnitude above one")
   `MWM_ASSERT_IMP(a_den_range, clock, reset, s5_vld_ff, (den5_ff >= ONE_S) && (den5_ff <= DEN_MAX), "divisor out of range")
   `MWM_ASSERT_NXT(a_load_out, clock, reset, div_out_valid && en_out, out_vld_ff, "divider result not registered")

endmodule

`default_nettype wire
